[hdl/bfha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;

   localparam int HEAP_BYTES_DEF = 4096;
   localparam int STRING_MAX_DEF = 256;

   // Chunk offsets wrap in this many bits.
   localparam int OFF_W = 12;
   localparam int ALIGN_SHIFT = 4;
   localparam int HDR_BYTES = 8;
   // Bit 12 marks an in-use chunk in word 0 and a valid link in words 2 and 3.
   localparam int MARK_BIT = 12;

   // Word slots inside a chunk header.
   localparam logic [1:0] W_FWD  = 2'd0;
   localparam logic [1:0] W_BACK = 2'd1;
   localparam logic [1:0] W_PREV = 2'd2;
   localparam logic [1:0] W_NEXT = 2'd3;

   localparam logic [2:0] MODE_INIT      = 3'd0;
   localparam logic [2:0] MODE_ALLOC     = 3'd1;
   localparam logic [2:0] MODE_FREE      = 3'd2;
   localparam logic [2:0] MODE_ALLOC_STR = 3'd3;
   localparam logic [2:0] MODE_FREE_STR  = 3'd4;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_RANGE = 2'd1;
   localparam logic [1:0] STS_DFREE = 2'd2;
   localparam logic [1:0] STS_FAIL  = 2'd3;

   localparam logic REG_HEAP_BASE = 1'b0;
   localparam logic REG_HEAP_SIZE = 1'b1;

   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [OFF_W-1:0]  off;
      logic [1:0]        word;
      logic [15:0]       wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic [15:0] heap_start;
      logic [12:0] eff_size;
      logic [12:0] heap_size;
      logic [15:0] rdata;
   } dp_status_type;

endpackage
`default_nettype wire

[hdl/bfha_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfha_datapath #(
   parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   input  wire bfha_pkg::mem_cmd_type cmd,
   output bfha_pkg::dp_status_type    sts
);
   import bfha_pkg::*;

   localparam int WORDS = HEAP_BYTES / 2;
   localparam int AW = $clog2(WORDS);

   logic [15:0] heap_base_ff;
   logic [12:0] heap_size_ff;
   logic        cfg_wr;
   logic [16:0] start_sum;
   logic [OFF_W-1:0] idx;
   logic        idx_ok;
   logic [15:0] mem [WORDS];
   logic [15:0] rdata_ff;
   logic        rok_ff;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_size_ff <= '0;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == REG_HEAP_BASE) heap_base_ff <= csr_pwdata[15:0];
         else heap_size_ff <= csr_pwdata[12:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_HEAP_BASE) csr_prdata = {16'd0, heap_base_ff};
      else csr_prdata = {19'd0, heap_size_ff};
   end

   assign start_sum = {1'b0, heap_base_ff} + 17'd15;
   assign sts.heap_start = {start_sum[15:4], 4'd0};
   assign sts.heap_size = heap_size_ff;
   assign sts.eff_size = (heap_size_ff > 13'(HEAP_BYTES)) ? 13'(HEAP_BYTES) : heap_size_ff;

   // Word index of a header slot; slots past the end of the array are dropped.
   assign idx = {1'b0, cmd.off[OFF_W-1:1]} + {10'd0, cmd.word};
   assign idx_ok = idx < OFF_W'(WORDS);

   always_ff @(posedge clock) begin
      if (cmd.wr && idx_ok) mem[idx[AW-1:0]] <= cmd.wdata;
      if (cmd.rd) begin
         rdata_ff <= mem[idx[AW-1:0]];
         rok_ff <= idx_ok;
      end
   end

   assign sts.rdata = rok_ff ? rdata_ff : 16'd0;

endmodule
`default_nettype wire

[hdl/bfha_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfha_controller #(
   parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF,
   parameter int STRING_MAX = bfha_pkg::STRING_MAX_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [2:0]              req_mode,
   input  wire logic [15:0]             req_size,
   input  wire logic [15:0]             req_address,
   input  wire logic                    req_string_flag,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [15:0]                  rsp_result_address,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_heap_string,
   output bfha_pkg::mem_cmd_type        cmd,
   input  wire bfha_pkg::dp_status_type sts
);
   import bfha_pkg::*;

   localparam int WALK_LIMIT = HEAP_BYTES / 8;
   localparam int WW = $clog2(WALK_LIMIT + 1);
   localparam int NS = 34;

   typedef enum logic [NS-1:0] {
      ST_IDLE     = NS'(1) << 0,  ST_DISPATCH = NS'(1) << 1,
      ST_INIT_W   = NS'(1) << 2,  ST_A_RD     = NS'(1) << 3,
      ST_A_CHK    = NS'(1) << 4,  ST_A_NXT    = NS'(1) << 5,
      ST_A_SET    = NS'(1) << 6,  ST_A_SPLIT  = NS'(1) << 7,
      ST_F_RD     = NS'(1) << 8,  ST_F_CHK    = NS'(1) << 9,
      ST_F_CLR    = NS'(1) << 10, ST_D_RD0    = NS'(1) << 11,
      ST_D_RD1    = NS'(1) << 12, ST_D_HDR    = NS'(1) << 13,
      ST_D_PRD    = NS'(1) << 14, ST_D_PCHK   = NS'(1) << 15,
      ST_D_PRD2   = NS'(1) << 16, ST_D_PMRG   = NS'(1) << 17,
      ST_D_PBACK  = NS'(1) << 18, ST_D_NRD    = NS'(1) << 19,
      ST_D_NCHK   = NS'(1) << 20, ST_D_NMRG   = NS'(1) << 21,
      ST_D_NBACK  = NS'(1) << 22, ST_R_RD2    = NS'(1) << 23,
      ST_R_RD3    = NS'(1) << 24, ST_R_W1     = NS'(1) << 25,
      ST_R_W2     = NS'(1) << 26, ST_L_RD     = NS'(1) << 27,
      ST_L_SZ     = NS'(1) << 28, ST_L_LOOP   = NS'(1) << 29,
      ST_L_CMP    = NS'(1) << 30, ST_L_NXT    = NS'(1) << 31,
      ST_L_LINK   = NS'(1) << 32, ST_DONE     = NS'(1) << 33
   } state_type;

   typedef enum logic [1:0] {RET_ALLOC, RET_PREV, RET_NEXT} ret_type;

   state_type        state_ff, state_in;
   ret_type          ret_ff, ret_in;
   logic [2:0]       mode_ff, mode_in;
   logic [15:0]      size_ff, size_in;
   logic [15:0]      addr_ff, addr_in;
   logic             flag_ff, flag_in;
   logic [OFF_W-1:0] c_ff, c_in, cf_ff, cf_in, n_ff, n_in, p_ff, p_in, nf_ff, nf_in;
   logic [OFF_W-1:0] x_ff, x_in, cur_ff, cur_in, prev_ff, prev_in, f_ff, f_in;
   logic [OFF_W-1:0] s_ff, s_in, sf_ff, sf_in, lsize_ff, lsize_in, head_ff, head_in;
   logic [15:0]      pl_ff, pl_in, nl_ff, nl_in;
   logic             has_next_ff, has_next_in, have_prev_ff, have_prev_in;
   logic             have_cur_ff, have_cur_in, head_valid_ff, head_valid_in;
   logic [WW-1:0]    walk_ff, walk_in;
   logic [16:0]      need_ff, need_in;
   logic [2:0]       k_ff, k_in;
   logic [15:0]      res_ff, res_in;
   logic [1:0]       status_ff, status_in;
   logic             hstr_ff, hstr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_addr_ff, rsp_addr_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_hstr_ff, rsp_hstr_in;

   logic [OFF_W-1:0] usable, rd_off;
   logic [12:0]      span;
   logic [16:0]      lo_lim, hi_lim, addr_top, need_calc;
   logic [15:0]      hdr_full;
   logic             rd_used;

   assign span = {sts.eff_size[12:4], 4'd0};
   assign usable = OFF_W'(span - 13'd16);
   assign lo_lim = {1'b0, sts.heap_start} + 17'(HDR_BYTES);
   assign hi_lim = {1'b0, sts.heap_start} + {4'd0, sts.eff_size};
   assign addr_top = {1'b0, addr_ff} + 17'd16;
   assign hdr_full = addr_ff - sts.heap_start - 16'(HDR_BYTES);
   assign need_calc = (({1'b0, size_ff} + 17'd15) & ~17'd15) + 17'(HDR_BYTES);
   assign rd_off = sts.rdata[OFF_W-1:0];
   assign rd_used = sts.rdata[MARK_BIT];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_heap_string = rsp_hstr_ff;

   always_comb begin
      state_in = state_ff;     ret_in = ret_ff;
      mode_in = mode_ff;       size_in = size_ff;     addr_in = addr_ff;  flag_in = flag_ff;
      c_in = c_ff;  cf_in = cf_ff;  n_in = n_ff;  p_in = p_ff;  nf_in = nf_ff;  x_in = x_ff;
      cur_in = cur_ff;  prev_in = prev_ff;  f_in = f_ff;  s_in = s_ff;  sf_in = sf_ff;
      lsize_in = lsize_ff;  head_in = head_ff;  pl_in = pl_ff;  nl_in = nl_ff;
      has_next_in = has_next_ff;  have_prev_in = have_prev_ff;  have_cur_in = have_cur_ff;
      head_valid_in = head_valid_ff;  walk_in = walk_ff;  need_in = need_ff;  k_in = k_ff;
      res_in = res_ff;  status_in = status_ff;  hstr_in = hstr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_addr_in = rsp_addr_ff;  rsp_status_in = rsp_status_ff;  rsp_hstr_in = rsp_hstr_ff;
      cmd = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_mode;  size_in = req_size;
               addr_in = req_address;  flag_in = req_string_flag;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_in = '0;  status_in = STS_OK;  hstr_in = 1'b0;  k_in = '0;
            state_in = ST_DONE;
            case (mode_ff)
               MODE_INIT: begin
                  if (sts.heap_size > 13'd32) state_in = ST_INIT_W;
               end
               MODE_ALLOC, MODE_ALLOC_STR: begin
                  if (size_ff == 16'd0 ||
                      (mode_ff == MODE_ALLOC_STR && size_ff > 16'(STRING_MAX))) begin
                     status_in = STS_FAIL;
                  end else begin
                     need_in = need_calc;  cur_in = head_ff;  have_cur_in = head_valid_ff;
                     walk_in = '0;  state_in = ST_A_RD;
                  end
               end
               MODE_FREE, MODE_FREE_STR: begin
                  if (mode_ff == MODE_FREE || flag_ff) begin
                     if ({1'b0, addr_ff} < lo_lim || addr_top >= hi_lim ||
                         hdr_full[2:0] != 3'd0) begin
                        status_in = STS_RANGE;
                     end else begin
                        c_in = hdr_full[OFF_W-1:0];  state_in = ST_F_RD;
                     end
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_INIT_W: begin
            cmd.wr = 1'b1;
            cmd.word = k_ff[1:0];
            cmd.off = k_ff[2] ? '0 : usable;
            case (k_ff)
               3'd0: cmd.wdata = 16'd1 << MARK_BIT;
               3'd1, 3'd4: cmd.wdata = {4'd0, usable};
               default: cmd.wdata = '0;
            endcase
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd7) begin
               head_in = '0;  head_valid_in = 1'b1;  state_in = ST_DONE;
            end
         end
         ST_A_RD: begin
            if (!have_cur_ff || walk_ff == WW'(WALK_LIMIT)) begin
               status_in = STS_FAIL;  state_in = ST_DONE;
            end else begin
               cmd.rd = 1'b1;  cmd.off = cur_ff;  cmd.word = W_FWD;  state_in = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if ({5'd0, rd_off} >= need_ff) begin
               f_in = rd_off;  x_in = cur_ff;  ret_in = RET_ALLOC;  state_in = ST_R_RD2;
            end else begin
               cmd.rd = 1'b1;  cmd.off = cur_ff;  cmd.word = W_NEXT;  state_in = ST_A_NXT;
            end
         end
         ST_A_NXT: begin
            have_cur_in = rd_used;  cur_in = rd_off;  walk_in = walk_ff + WW'(1);
            state_in = ST_A_RD;
         end
         ST_A_SET: begin
            cmd.wr = 1'b1;  cmd.off = cur_ff;  cmd.word = W_FWD;
            cmd.wdata = {3'd0, 1'b1, f_ff};
            res_in = sts.heap_start + {4'd0, cur_ff} + 16'(HDR_BYTES);
            hstr_in = (mode_ff == MODE_ALLOC_STR);
            k_in = '0;
            if ({5'd0, f_ff} > need_ff + 17'd16) begin
               s_in = cur_ff + need_ff[OFF_W-1:0];
               sf_in = f_ff - need_ff[OFF_W-1:0];
               state_in = ST_A_SPLIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_A_SPLIT: begin
            cmd.wr = 1'b1;  cmd.off = s_ff;  cmd.word = k_ff[1:0];  cmd.wdata = '0;
            k_in = k_ff + 3'd1;
            case (k_ff)
               3'd0: cmd.wdata = {4'd0, sf_ff};
               3'd1: cmd.wdata = {4'd0, need_ff[OFF_W-1:0]};
               3'd4: begin
                  cmd.off = cur_ff;  cmd.word = W_FWD;
                  cmd.wdata = {3'd0, 1'b1, need_ff[OFF_W-1:0]};
               end
               3'd5: begin
                  cmd.off = s_ff + sf_ff;  cmd.word = W_BACK;  cmd.wdata = {4'd0, sf_ff};
                  c_in = s_ff;  state_in = ST_D_RD0;
               end
               default: cmd.wdata = '0;
            endcase
         end
         ST_F_RD: begin
            cmd.rd = 1'b1;  cmd.off = c_ff;  cmd.word = W_FWD;  state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            if (!rd_used) begin
               status_in = STS_DFREE;  state_in = ST_DONE;
            end else begin
               k_in = '0;  state_in = ST_F_CLR;
            end
         end
         ST_F_CLR: begin
            cmd.wr = 1'b1;  cmd.off = c_ff;  cmd.word = k_ff[0] ? W_NEXT : W_PREV;
            k_in = k_ff + 3'd1;
            if (k_ff[0]) state_in = ST_D_RD0;
         end
         ST_D_RD0: begin
            cmd.rd = 1'b1;  cmd.off = c_ff;  cmd.word = W_FWD;  state_in = ST_D_RD1;
         end
         ST_D_RD1: begin
            cf_in = rd_off;
            cmd.rd = 1'b1;  cmd.off = c_ff;  cmd.word = W_BACK;  state_in = ST_D_HDR;
         end
         ST_D_HDR: begin
            cmd.wr = 1'b1;  cmd.off = c_ff;  cmd.word = W_FWD;  cmd.wdata = {4'd0, cf_ff};
            has_next_in = (cf_ff != '0);
            n_in = c_ff + cf_ff;
            p_in = c_ff - rd_off;
            state_in = (rd_off != '0) ? ST_D_PRD : ST_D_NRD;
         end
         ST_D_PRD: begin
            cmd.rd = 1'b1;  cmd.off = p_ff;  cmd.word = W_FWD;  state_in = ST_D_PCHK;
         end
         ST_D_PCHK: begin
            if (rd_used) state_in = ST_D_NRD;
            else begin
               x_in = p_ff;  ret_in = RET_PREV;  state_in = ST_R_RD2;
            end
         end
         ST_D_PRD2: begin
            cmd.rd = 1'b1;  cmd.off = p_ff;  cmd.word = W_FWD;  state_in = ST_D_PMRG;
         end
         ST_D_PMRG: begin
            cf_in = rd_off + cf_ff;
            cmd.wr = 1'b1;  cmd.off = p_ff;  cmd.word = W_FWD;
            cmd.wdata = {4'd0, rd_off + cf_ff};
            c_in = p_ff;
            state_in = has_next_ff ? ST_D_PBACK : ST_D_NRD;
         end
         ST_D_PBACK: begin
            cmd.wr = 1'b1;  cmd.off = n_ff;  cmd.word = W_BACK;  cmd.wdata = {4'd0, cf_ff};
            state_in = ST_D_NRD;
         end
         ST_D_NRD: begin
            if (!has_next_ff) state_in = ST_L_RD;
            else begin
               cmd.rd = 1'b1;  cmd.off = n_ff;  cmd.word = W_FWD;  state_in = ST_D_NCHK;
            end
         end
         ST_D_NCHK: begin
            if (rd_used) state_in = ST_L_RD;
            else begin
               nf_in = rd_off;  x_in = n_ff;  ret_in = RET_NEXT;  state_in = ST_R_RD2;
            end
         end
         ST_D_NMRG: begin
            cf_in = cf_ff + nf_ff;
            cmd.wr = 1'b1;  cmd.off = c_ff;  cmd.word = W_FWD;
            cmd.wdata = {4'd0, cf_ff + nf_ff};
            state_in = (nf_ff != '0) ? ST_D_NBACK : ST_L_RD;
         end
         ST_D_NBACK: begin
            cmd.wr = 1'b1;  cmd.off = n_ff + nf_ff;  cmd.word = W_BACK;
            cmd.wdata = {4'd0, cf_ff};
            state_in = ST_L_RD;
         end
         ST_R_RD2: begin
            cmd.rd = 1'b1;  cmd.off = x_ff;  cmd.word = W_PREV;  state_in = ST_R_RD3;
         end
         ST_R_RD3: begin
            pl_in = sts.rdata;
            cmd.rd = 1'b1;  cmd.off = x_ff;  cmd.word = W_NEXT;  state_in = ST_R_W1;
         end
         ST_R_W1: begin
            nl_in = sts.rdata;
            if (pl_ff[MARK_BIT]) begin
               cmd.wr = 1'b1;  cmd.off = pl_ff[OFF_W-1:0];  cmd.word = W_NEXT;
               cmd.wdata = sts.rdata;
            end else begin
               head_valid_in = rd_used;
               head_in = rd_used ? rd_off : '0;
            end
            state_in = ST_R_W2;
         end
         ST_R_W2: begin
            if (nl_ff[MARK_BIT]) begin
               cmd.wr = 1'b1;  cmd.off = nl_ff[OFF_W-1:0];  cmd.word = W_PREV;
               cmd.wdata = pl_ff;
            end
            case (ret_ff)
               RET_ALLOC: state_in = ST_A_SET;
               RET_PREV:  state_in = ST_D_PRD2;
               RET_NEXT:  state_in = ST_D_NMRG;
               default:   state_in = ST_A_SET;
            endcase
         end
         ST_L_RD: begin
            cmd.rd = 1'b1;  cmd.off = c_ff;  cmd.word = W_FWD;  state_in = ST_L_SZ;
         end
         ST_L_SZ: begin
            lsize_in = rd_off;  prev_in = '0;  have_prev_in = 1'b0;
            have_cur_in = head_valid_ff;  cur_in = head_ff;  walk_in = '0;
            state_in = ST_L_LOOP;
         end
         ST_L_LOOP: begin
            k_in = '0;
            if (walk_ff == WW'(WALK_LIMIT)) begin
               have_cur_in = 1'b0;  state_in = ST_L_LINK;
            end else if (!have_cur_ff) begin
               state_in = ST_L_LINK;
            end else begin
               cmd.rd = 1'b1;  cmd.off = cur_ff;  cmd.word = W_FWD;  state_in = ST_L_CMP;
            end
         end
         ST_L_CMP: begin
            if (rd_off >= lsize_ff) state_in = ST_L_LINK;
            else begin
               cmd.rd = 1'b1;  cmd.off = cur_ff;  cmd.word = W_NEXT;  state_in = ST_L_NXT;
            end
         end
         ST_L_NXT: begin
            prev_in = cur_ff;  have_prev_in = 1'b1;
            have_cur_in = rd_used;  cur_in = rd_off;  walk_in = walk_ff + WW'(1);
            state_in = ST_L_LOOP;
         end
         ST_L_LINK: begin
            k_in = k_ff + 3'd1;
            case (k_ff[1:0])
               2'd0: begin
                  cmd.wr = 1'b1;  cmd.off = c_ff;  cmd.word = W_PREV;
                  cmd.wdata = have_prev_ff ? {3'd0, 1'b1, prev_ff} : 16'd0;
               end
               2'd1: begin
                  cmd.wr = 1'b1;  cmd.off = c_ff;  cmd.word = W_NEXT;
                  cmd.wdata = have_cur_ff ? {3'd0, 1'b1, cur_ff} : 16'd0;
               end
               2'd2: begin
                  if (have_prev_ff) begin
                     cmd.wr = 1'b1;  cmd.off = prev_ff;  cmd.word = W_NEXT;
                     cmd.wdata = {3'd0, 1'b1, c_ff};
                  end else begin
                     head_in = c_ff;  head_valid_in = 1'b1;
                  end
               end
               default: begin
                  if (have_cur_ff) begin
                     cmd.wr = 1'b1;  cmd.off = cur_ff;  cmd.word = W_PREV;
                     cmd.wdata = {3'd0, 1'b1, c_ff};
                  end
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;  rsp_addr_in = res_ff;
               rsp_status_in = status_ff;  rsp_hstr_in = hstr_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         head_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         walk_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  mode_ff <= mode_in;  size_ff <= size_in;
      addr_ff <= addr_in;  flag_ff <= flag_in;
      c_ff <= c_in;  cf_ff <= cf_in;  n_ff <= n_in;  p_ff <= p_in;  nf_ff <= nf_in;
      x_ff <= x_in;  cur_ff <= cur_in;  prev_ff <= prev_in;  f_ff <= f_in;
      s_ff <= s_in;  sf_ff <= sf_in;  lsize_ff <= lsize_in;
      pl_ff <= pl_in;  nl_ff <= nl_in;
      has_next_ff <= has_next_in;  have_prev_ff <= have_prev_in;  have_cur_ff <= have_cur_in;
      need_ff <= need_in;  k_ff <= k_in;
      res_ff <= res_in;  status_ff <= status_in;  hstr_ff <= hstr_in;
      rsp_addr_ff <= rsp_addr_in;  rsp_status_ff <= rsp_status_in;  rsp_hstr_ff <= rsp_hstr_in;
   end

`ifndef SYNTH
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request did not enter dispatch");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= WW'(WALK_LIMIT))
      else $error("list walk ran past its bound");
   a_head_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(head_valid_ff) |-> ($past(state_ff) == ST_INIT_W ||
                                $past(state_ff) == ST_L_LINK ||
                                $past(state_ff) == ST_R_W1))
      else $error("free list became non-empty outside a list update");
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("finished result was not presented");
`endif

endmodule
`default_nettype wire

[hdl/best_fit_heap_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Transfer                      Payload
// req_      in   req_tvalid & req_tready       mode, size, address, string_flag
// rsp_      out  rsp_tvalid & rsp_tready       result_address, status, heap_string
// csr_      in   psel & penable & pwrite       heap_base (0x0), heap_size (0x4)
//
// One request is in service at a time; memory slots are accessed one at a time.
// Init writes one free chunk and an in-use end marker. Allocate walks the free
// list entry by entry; a split-off remainder is freed and the list walked again.
// Free merges a chunk with free neighbours and walks the list for reinsertion.
// Reset is synchronous; the header memory needs no clearing pass.
// A stalled result sits in the output register while the next request is taken.
module best_fit_heap_allocator_core #(
   parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF,
   parameter int STRING_MAX = bfha_pkg::STRING_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] size, [31:16] address, [39:32] zero
   input  wire logic [39:0] req_tdata,
   // [2:0] mode, [3] string_flag
   input  wire logic [3:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] result_address
   output logic [15:0]      rsp_tdata,
   // [1:0] status, [2] heap_string
   output logic [2:0]       rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bfha_pkg::*;

   // Commands flow from the sequencer to the memory side; status flows back.
   mem_cmd_type   cmd;
   dp_status_type sts;
   logic [1:0]    status;
   logic          heap_string;

   bfha_controller #(
      .HEAP_BYTES(HEAP_BYTES),
      .STRING_MAX(STRING_MAX)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_mode(req_tuser[2:0]),
      .req_size(req_tdata[15:0]),
      .req_address(req_tdata[31:16]),
      .req_string_flag(req_tuser[3]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_result_address(rsp_tdata),
      .rsp_status(status),
      .rsp_heap_string(heap_string),
      .cmd(cmd),
      .sts(sts)
   );

   bfha_datapath #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cmd(cmd),
      .sts(sts)
   );

   assign rsp_tuser = {heap_string, status};

endmodule
`default_nettype wire
